[sv/rbmj_pkg.sv]
// Shared types, widths and constants for the range and bearing measurement pipeline.
// Used by the square-root and CORDIC cells and the top module; depends on nothing else.
package rbmj_pkg;

   // Fixed-point constants: pi in Q3.13, and pi/2 in the CORDIC angle unit of 2^-28 rad.
   localparam logic signed [15:0] PI_Q13    = 16'sd25736;
   localparam logic signed [31:0] HALF_PI_Z = 32'sd421657428;

   // Pipeline step counts that follow from the fixed field widths.
   localparam int SQRT_STEPS = 34;   // one root bit per cell, 68-bit radicand
   localparam int UNIT_QW    = 15;   // quotient bits of dx/d and dy/d
   localparam int INV_QW     = 33;   // quotient bits of the inverse-distance terms

   // Datapath widths.
   localparam int SQ_REM_W  = 38;
   localparam int SQ_ROOT_W = 34;
   localparam int SQ_RAD_W  = 68;
   localparam int CX_W      = 36;    // CORDIC x and y
   localparam int CZ_W      = 32;    // CORDIC angle accumulator
   localparam int UNIT_RW   = 34;    // remainder and divisor of the unit terms
   localparam int INV_RW    = 67;    // remainder and divisor of the inverse terms

   typedef struct packed {
      logic signed [31:0] veh_x;
      logic signed [31:0] veh_y;
      logic signed [15:0] veh_heading;
      logic signed [31:0] lm_x;
      logic signed [31:0] lm_y;
   } req_type;

   typedef struct packed {
      logic        [32:0] range_out;
      logic signed [15:0] bearing_out;
      logic signed [15:0] jac_range_lx;
      logic signed [31:0] jac_bearing_lx;
      logic signed [15:0] jac_range_ly;
      logic signed [31:0] jac_bearing_ly;
      logic               degenerate;
   } rsp_type;

   // Per-item side information that travels alongside the arithmetic.
   typedef struct packed {
      logic signed [15:0] head;
      logic               degen;
      logic               neg_x;
      logic               neg_y;
      logic               pos_y;
   } flag_type;

   // Arctangent of 2^-i in units of 2^-28 rad.
   function automatic logic [31:0] atan_entry(input logic [4:0] idx);
      logic [31:0] val;
      case (idx)
         5'd0:  val = 32'd210828714;
         5'd1:  val = 32'd124459457;
         5'd2:  val = 32'd65760959;
         5'd3:  val = 32'd33381290;
         5'd4:  val = 32'd16755422;
         5'd5:  val = 32'd8385879;
         5'd6:  val = 32'd4193963;
         5'd7:  val = 32'd2097109;
         5'd8:  val = 32'd1048571;
         5'd9:  val = 32'd524287;
         5'd10: val = 32'd262144;
         5'd11: val = 32'd131072;
         5'd12: val = 32'd65536;
         5'd13: val = 32'd32768;
         5'd14: val = 32'd16384;
         5'd15: val = 32'd8192;
         5'd16: val = 32'd4096;
         5'd17: val = 32'd2048;
         5'd18: val = 32'd1024;
         5'd19: val = 32'd512;
         5'd20: val = 32'd256;
         5'd21: val = 32'd128;
         5'd22: val = 32'd64;
         5'd23: val = 32'd32;
         5'd24: val = 32'd16;
         5'd25: val = 32'd8;
         5'd26: val = 32'd4;
         5'd27: val = 32'd2;
         5'd28: val = 32'd1;
         default: val = 32'd0;
      endcase
      return val;
   endfunction

endpackage

[sv/rbmj_delay.sv]
// Enabled shift line that carries side data alongside the pipeline.
// Stand-alone; has no package dependency.
module rbmj_delay #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 1
) (
   input  logic             clock,
   input  logic             enable,
   input  logic [WIDTH-1:0] d,
   output logic [WIDTH-1:0] q
);

   logic [WIDTH-1:0] tap_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (enable) begin
         tap_ff[0] <= d;
         for (int i = 1; i < DEPTH; i++) begin
            tap_ff[i] <= tap_ff[i-1];
         end
      end
   end

   assign q = tap_ff[DEPTH-1];

endmodule

[sv/rbmj_sqrt_cell.sv]
// One cell of the digit-by-digit square root: settles one root bit per cycle while enabled.
// Depends on rbmj_pkg for its widths.
module rbmj_sqrt_cell (
   input  logic                           clock,
   input  logic                           enable,
   input  logic [rbmj_pkg::SQ_REM_W-1:0]  up_rem,
   input  logic [rbmj_pkg::SQ_ROOT_W-1:0] up_root,
   input  logic [rbmj_pkg::SQ_RAD_W-1:0]  up_rad,
   output logic [rbmj_pkg::SQ_REM_W-1:0]  dn_rem,
   output logic [rbmj_pkg::SQ_ROOT_W-1:0] dn_root,
   output logic [rbmj_pkg::SQ_RAD_W-1:0]  dn_rad
);

   logic [rbmj_pkg::SQ_REM_W-1:0]  cur;
   logic [rbmj_pkg::SQ_REM_W-1:0]  trial;
   logic                           ge;
   logic [rbmj_pkg::SQ_REM_W-1:0]  rem_in,  rem_ff;
   logic [rbmj_pkg::SQ_ROOT_W-1:0] root_in, root_ff;
   logic [rbmj_pkg::SQ_RAD_W-1:0]  rad_in,  rad_ff;

   // Bring down the next two radicand bits and try the root bit as one.
   always_comb begin
      cur     = {up_rem[rbmj_pkg::SQ_REM_W-3:0], up_rad[rbmj_pkg::SQ_RAD_W-1 -: 2]};
      trial   = {2'b00, up_root, 2'b01};
      ge      = (cur >= trial);
      rem_in  = ge ? (cur - trial) : cur;
      root_in = {up_root[rbmj_pkg::SQ_ROOT_W-2:0], ge};
      rad_in  = {up_rad[rbmj_pkg::SQ_RAD_W-3:0], 2'b00};
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         rem_ff  <= rem_in;
         root_ff <= root_in;
         rad_ff  <= rad_in;
      end
   end

   assign dn_rem  = rem_ff;
   assign dn_root = root_ff;
   assign dn_rad  = rad_ff;

endmodule

[sv/rbmj_div_cell.sv]
// One cell of a restoring divider: settles one quotient bit per cycle while enabled.
// Stand-alone; widths are set by the instantiating module.
module rbmj_div_cell #(
   parameter int RW = 34,
   parameter int QW = 15
) (
   input  logic          clock,
   input  logic          enable,
   input  logic [RW-1:0] up_rem,
   input  logic [RW-1:0] up_den,
   input  logic [QW-1:0] up_quo,
   output logic [RW-1:0] dn_rem,
   output logic [RW-1:0] dn_den,
   output logic [QW-1:0] dn_quo
);

   logic          ge;
   logic [RW-1:0] diff;
   logic [RW-1:0] rem_in, rem_ff;
   logic [RW-1:0] den_ff;
   logic [QW-1:0] quo_in, quo_ff;

   // The partial remainder stays below twice the divisor, so one compare
   // decides the bit; the doubled remainder goes on to the next cell.
   always_comb begin
      ge     = (up_rem >= up_den);
      diff   = up_rem - up_den;
      rem_in = ge ? {diff[RW-2:0], 1'b0} : {up_rem[RW-2:0], 1'b0};
      quo_in = {up_quo[QW-2:0], ge};
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         rem_ff <= rem_in;
         den_ff <= up_den;
         quo_ff <= quo_in;
      end
   end

   assign dn_rem = rem_ff;
   assign dn_den = den_ff;
   assign dn_quo = quo_ff;

endmodule

[sv/rbmj_cordic_cell.sv]
// One vectoring CORDIC micro-rotation, registered.
// Depends on rbmj_pkg for widths and the arctangent table.
module rbmj_cordic_cell #(
   parameter int IDX = 0
) (
   input  logic                             clock,
   input  logic                             enable,
   input  logic signed [rbmj_pkg::CX_W-1:0] up_x,
   input  logic signed [rbmj_pkg::CX_W-1:0] up_y,
   input  logic signed [rbmj_pkg::CZ_W-1:0] up_z,
   output logic signed [rbmj_pkg::CX_W-1:0] dn_x,
   output logic signed [rbmj_pkg::CX_W-1:0] dn_y,
   output logic signed [rbmj_pkg::CZ_W-1:0] dn_z
);

   logic signed [rbmj_pkg::CX_W-1:0] xs, ys;
   logic signed [rbmj_pkg::CZ_W-1:0] ang;
   logic signed [rbmj_pkg::CX_W-1:0] x_in, x_ff, y_in, y_ff;
   logic signed [rbmj_pkg::CZ_W-1:0] z_in, z_ff;

   always_comb begin
      xs  = up_x >>> IDX;
      ys  = up_y >>> IDX;
      ang = $signed(rbmj_pkg::atan_entry(5'(IDX)));
      if (!up_y[rbmj_pkg::CX_W-1]) begin
         x_in = up_x + ys;
         y_in = up_y - xs;
         z_in = up_z + ang;
      end else begin
         x_in = up_x - ys;
         y_in = up_y + xs;
         z_in = up_z - ang;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         x_ff <= x_in;
         y_ff <= y_in;
         z_ff <= z_in;
      end
   end

   assign dn_x = x_ff;
   assign dn_y = y_ff;
   assign dn_z = z_ff;

endmodule

[sv/range_bearing_measurement_jacobian.sv]
// Range-bearing measurement model with landmark Jacobian, fully pipelined.
// Depends on rbmj_pkg and the cell modules rbmj_delay, rbmj_sqrt_cell,
// rbmj_div_cell and rbmj_cordic_cell.
//
// The block takes one transfer per clock while req_stall is low and returns one result transfer
// per input, in order. The longest chain is one offset stage, one multiply stage, one sum stage,
// 34 square-root cells (one root bit each), a rounding stage, 15 divider cells for the unit terms
// and the output register. The bearing runs through CORDIC_STAGES CORDIC cells in parallel, and
// the inverse-distance terms through 33 divider cells fed from the exact squared distance; their
// results wait in shift lines until the unit terms are done. The whole pipeline moves as one:
// when a finished result is held by rsp_stall, every stage holds and req_stall is raised, so
// throughput is one item per cycle whenever the consumer takes results as they come. The
// Jacobian terms are forced to zero and the degenerate flag is set when the landmark lies on
// the vehicle position.
module range_bearing_measurement_jacobian #(
   parameter int CORDIC_STAGES = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  rbmj_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output rbmj_pkg::rsp_type rsp_data
);

   // Stage numbering: the offset registers are stage 1, the output register is stage LAT.
   localparam int S_RNG    = 4 + rbmj_pkg::SQRT_STEPS;         // rounded range ready
   localparam int S_PRE    = S_RNG + rbmj_pkg::UNIT_QW;        // last stage before output
   localparam int LAT      = S_PRE + 1;
   localparam int S_INVRND = 4 + rbmj_pkg::INV_QW;             // rounded inverse terms ready
   localparam int S_CEND   = 2 + CORDIC_STAGES;                // last CORDIC cell
   localparam int S_BRG    = S_CEND + 1;                       // wrapped bearing ready

   localparam int UQ = rbmj_pkg::UNIT_QW;
   localparam int IQ = rbmj_pkg::INV_QW;
   localparam int UR = rbmj_pkg::UNIT_RW;
   localparam int IR = rbmj_pkg::INV_RW;
   localparam int CX = rbmj_pkg::CX_W;
   localparam int CZ = rbmj_pkg::CZ_W;

   // ------------------------------------------------------------------
   // Flow control: one global advance for the whole pipeline.
   // ------------------------------------------------------------------
   logic           adv;
   logic [LAT-1:0] vld_in, vld_ff;

   assign adv       = !vld_ff[LAT-1] || !rsp_stall;
   assign req_stall = !adv;
   assign vld_in    = {vld_ff[LAT-2:0], req_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= vld_in;
      end
   end

   assign rsp_valid = vld_ff[LAT-1];

   // ------------------------------------------------------------------
   // Stage 1: exact offsets, magnitudes and sign flags.
   // ------------------------------------------------------------------
   logic signed [32:0] dx_in, dy_in, dx_ff, dy_ff;
   logic        [32:0] ax_in, ay_in, ax_ff, ay_ff;
   rbmj_pkg::flag_type flag_in, flag_ff;

   always_comb begin
      dx_in = $signed({req_data.lm_x[31], req_data.lm_x})
            - $signed({req_data.veh_x[31], req_data.veh_x});
      dy_in = $signed({req_data.lm_y[31], req_data.lm_y})
            - $signed({req_data.veh_y[31], req_data.veh_y});
      ax_in = dx_in[32] ? 33'(-dx_in) : 33'(dx_in);
      ay_in = dy_in[32] ? 33'(-dy_in) : 33'(dy_in);
      flag_in.head  = req_data.veh_heading;
      flag_in.degen = (dx_in == '0) && (dy_in == '0);
      flag_in.neg_x = dx_in[32];
      flag_in.neg_y = dy_in[32];
      flag_in.pos_y = !dy_in[32] && (dy_in != '0);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         dx_ff   <= dx_in;
         dy_ff   <= dy_in;
         ax_ff   <= ax_in;
         ay_ff   <= ay_in;
         flag_ff <= flag_in;
      end
   end

   // ------------------------------------------------------------------
   // Stages 2 and 3: squares, then the exact squared distance.
   // ------------------------------------------------------------------
   logic [65:0] sqx_in, sqy_in, sqx_ff, sqy_ff;
   logic [65:0] n_in, n_ff;

   assign sqx_in = ax_ff * ax_ff;
   assign sqy_in = ay_ff * ay_ff;
   assign n_in   = sqx_ff + sqy_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         sqx_ff <= sqx_in;
         sqy_ff <= sqy_in;
         n_ff   <= n_in;
      end
   end

   // Magnitudes follow the squared distance to stage 3, then on to the range.
   logic [65:0] mag_s3, mag_rng;

   rbmj_delay #(.WIDTH(66), .DEPTH(2)) u_mag_a (
      .clock(clock), .enable(adv), .d({ax_ff, ay_ff}), .q(mag_s3)
   );
   rbmj_delay #(.WIDTH(66), .DEPTH(S_RNG - 3)) u_mag_b (
      .clock(clock), .enable(adv), .d(mag_s3), .q(mag_rng)
   );

   // ------------------------------------------------------------------
   // Square root: one cell per root bit, then round to nearest.
   // ------------------------------------------------------------------
   logic [rbmj_pkg::SQ_REM_W-1:0]  sq_rem  [rbmj_pkg::SQRT_STEPS+1];
   logic [rbmj_pkg::SQ_ROOT_W-1:0] sq_root [rbmj_pkg::SQRT_STEPS+1];
   logic [rbmj_pkg::SQ_RAD_W-1:0]  sq_rad  [rbmj_pkg::SQRT_STEPS+1];

   assign sq_rem[0]  = '0;
   assign sq_root[0] = '0;
   assign sq_rad[0]  = {2'b00, n_ff};

   for (genvar j = 0; j < rbmj_pkg::SQRT_STEPS; j++) begin : g_sqrt
      rbmj_sqrt_cell u_cell (
         .clock(clock), .enable(adv),
         .up_rem(sq_rem[j]),   .up_root(sq_root[j]),   .up_rad(sq_rad[j]),
         .dn_rem(sq_rem[j+1]), .dn_root(sq_root[j+1]), .dn_rad(sq_rad[j+1])
      );
   end

   logic [32:0] rng_in, rng_ff;
   logic        rng_up;

   // Round up when the remainder exceeds the floor root (n > r*r + r).
   assign rng_up = (sq_rem[rbmj_pkg::SQRT_STEPS] >
                    {4'd0, sq_root[rbmj_pkg::SQRT_STEPS]});
   assign rng_in = 33'(sq_root[rbmj_pkg::SQRT_STEPS] + {33'd0, rng_up});

   always_ff @(posedge clock) begin
      if (adv) begin
         rng_ff <= rng_in;
      end
   end

   logic [32:0] rng_pre;

   rbmj_delay #(.WIDTH(33), .DEPTH(S_PRE - S_RNG)) u_rng (
      .clock(clock), .enable(adv), .d(rng_ff), .q(rng_pre)
   );

   // ------------------------------------------------------------------
   // Unit terms dx/d and dy/d: two divider lanes against the rounded range.
   // ------------------------------------------------------------------
   logic [UR-1:0] ux_rem [UQ+1], ux_den [UQ+1];
   logic [UQ-1:0] ux_quo [UQ+1];
   logic [UR-1:0] uy_rem [UQ+1], uy_den [UQ+1];
   logic [UQ-1:0] uy_quo [UQ+1];

   assign ux_rem[0] = {1'b0, mag_rng[65:33]};
   assign uy_rem[0] = {1'b0, mag_rng[32:0]};
   assign ux_den[0] = {1'b0, rng_ff};
   assign uy_den[0] = {1'b0, rng_ff};
   assign ux_quo[0] = '0;
   assign uy_quo[0] = '0;

   for (genvar k = 0; k < UQ; k++) begin : g_unit
      rbmj_div_cell #(.RW(UR), .QW(UQ)) u_x (
         .clock(clock), .enable(adv),
         .up_rem(ux_rem[k]),   .up_den(ux_den[k]),   .up_quo(ux_quo[k]),
         .dn_rem(ux_rem[k+1]), .dn_den(ux_den[k+1]), .dn_quo(ux_quo[k+1])
      );
      rbmj_div_cell #(.RW(UR), .QW(UQ)) u_y (
         .clock(clock), .enable(adv),
         .up_rem(uy_rem[k]),   .up_den(uy_den[k]),   .up_quo(uy_quo[k]),
         .dn_rem(uy_rem[k+1]), .dn_den(uy_den[k+1]), .dn_quo(uy_quo[k+1])
      );
   end

   // ------------------------------------------------------------------
   // Inverse terms |dy|/d^2 and |dx|/d^2 against the exact squared distance.
   // ------------------------------------------------------------------
   logic [IR-1:0] ix_rem [IQ+1], ix_den [IQ+1];
   logic [IQ-1:0] ix_quo [IQ+1];
   logic [IR-1:0] iy_rem [IQ+1], iy_den [IQ+1];
   logic [IQ-1:0] iy_quo [IQ+1];

   // The x-lane term of the bearing row takes |dy|, the y-lane term takes |dx|.
   assign ix_rem[0] = {34'd0, mag_s3[32:0]};
   assign iy_rem[0] = {34'd0, mag_s3[65:33]};
   assign ix_den[0] = {1'b0, n_ff};
   assign iy_den[0] = {1'b0, n_ff};
   assign ix_quo[0] = '0;
   assign iy_quo[0] = '0;

   for (genvar m = 0; m < IQ; m++) begin : g_inv
      rbmj_div_cell #(.RW(IR), .QW(IQ)) u_x (
         .clock(clock), .enable(adv),
         .up_rem(ix_rem[m]),   .up_den(ix_den[m]),   .up_quo(ix_quo[m]),
         .dn_rem(ix_rem[m+1]), .dn_den(ix_den[m+1]), .dn_quo(ix_quo[m+1])
      );
      rbmj_div_cell #(.RW(IR), .QW(IQ)) u_y (
         .clock(clock), .enable(adv),
         .up_rem(iy_rem[m]),   .up_den(iy_den[m]),   .up_quo(iy_quo[m]),
         .dn_rem(iy_rem[m+1]), .dn_den(iy_den[m+1]), .dn_quo(iy_quo[m+1])
      );
   end

   // Round to nearest: the last cell leaves twice the remainder.
   logic [IQ:0] ixr_in, ixr_ff, iyr_in, iyr_ff;

   assign ixr_in = {1'b0, ix_quo[IQ]} + {{IQ{1'b0}}, (ix_rem[IQ] >= ix_den[IQ])};
   assign iyr_in = {1'b0, iy_quo[IQ]} + {{IQ{1'b0}}, (iy_rem[IQ] >= iy_den[IQ])};

   always_ff @(posedge clock) begin
      if (adv) begin
         ixr_ff <= ixr_in;
         iyr_ff <= iyr_in;
      end
   end

   logic [2*IQ+1:0] inv_pre;

   rbmj_delay #(.WIDTH(2*IQ+2), .DEPTH(S_PRE - S_INVRND)) u_inv (
      .clock(clock), .enable(adv), .d({ixr_ff, iyr_ff}), .q(inv_pre)
   );

   // ------------------------------------------------------------------
   // Bearing: quadrant turn, CORDIC cells, then round, subtract heading, wrap.
   // ------------------------------------------------------------------
   logic signed [CX-1:0] cx0_in, cy0_in;
   logic signed [CZ-1:0] cz0_in;
   logic signed [CX-1:0] cx [CORDIC_STAGES+1], cy [CORDIC_STAGES+1];
   logic signed [CZ-1:0] cz [CORDIC_STAGES+1];
   logic signed [CX-1:0] xw, yw;

   // Left half-plane vectors are turned by a quarter turn into the right half.
   always_comb begin
      xw = {{(CX-33){dx_ff[32]}}, dx_ff};
      yw = {{(CX-33){dy_ff[32]}}, dy_ff};
      if (!dx_ff[32]) begin
         cx0_in = xw;
         cy0_in = yw;
         cz0_in = '0;
      end else if (!dy_ff[32]) begin
         cx0_in = yw;
         cy0_in = -xw;
         cz0_in = rbmj_pkg::HALF_PI_Z;
      end else begin
         cx0_in = -yw;
         cy0_in = xw;
         cz0_in = -rbmj_pkg::HALF_PI_Z;
      end
   end

   logic signed [CX-1:0] cx0_ff, cy0_ff;
   logic signed [CZ-1:0] cz0_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         cx0_ff <= cx0_in;
         cy0_ff <= cy0_in;
         cz0_ff <= cz0_in;
      end
   end

   assign cx[0] = cx0_ff;
   assign cy[0] = cy0_ff;
   assign cz[0] = cz0_ff;

   for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cordic
      rbmj_cordic_cell #(.IDX(i)) u_cell (
         .clock(clock), .enable(adv),
         .up_x(cx[i]),   .up_y(cy[i]),   .up_z(cz[i]),
         .dn_x(cx[i+1]), .dn_y(cy[i+1]), .dn_z(cz[i+1])
      );
   end

   logic [$bits(rbmj_pkg::flag_type)-1:0] flag_cend_bits, flag_pre_bits;
   rbmj_pkg::flag_type                    flag_cend, flag_pre;

   rbmj_delay #(.WIDTH($bits(rbmj_pkg::flag_type)), .DEPTH(S_CEND - 1)) u_flag_a (
      .clock(clock), .enable(adv), .d(flag_ff), .q(flag_cend_bits)
   );
   rbmj_delay #(.WIDTH($bits(rbmj_pkg::flag_type)), .DEPTH(S_PRE - S_CEND)) u_flag_b (
      .clock(clock), .enable(adv), .d(flag_cend_bits), .q(flag_pre_bits)
   );

   assign flag_cend = rbmj_pkg::flag_type'(flag_cend_bits);
   assign flag_pre  = rbmj_pkg::flag_type'(flag_pre_bits);

   logic signed [CZ:0]  zr;
   logic signed [17:0]  ang;
   logic signed [18:0]  brg;
   logic signed [15:0]  brg_in, brg_ff;

   // Round the angle to Q3.13 with half up; a landmark on the vehicle uses angle zero.
   // One correction by a full turn is always enough to land in plus or minus pi.
   always_comb begin
      zr  = {cz[CORDIC_STAGES][CZ-1], cz[CORDIC_STAGES]} + (CZ+1)'(16384);
      ang = flag_cend.degen ? 18'sd0 : zr[CZ:15];
      brg = {ang[17], ang} - {{3{flag_cend.head[15]}}, flag_cend.head};
      if (brg > 19'(rbmj_pkg::PI_Q13)) begin
         brg = brg - 19'sd51472;
      end else if (brg < -19'(rbmj_pkg::PI_Q13)) begin
         brg = brg + 19'sd51472;
      end
      brg_in = brg[15:0];
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         brg_ff <= brg_in;
      end
   end

   logic [15:0] brg_pre;

   rbmj_delay #(.WIDTH(16), .DEPTH(S_PRE - S_BRG)) u_brg (
      .clock(clock), .enable(adv), .d(brg_ff), .q(brg_pre)
   );

   // ------------------------------------------------------------------
   // Output register: rounding, clamping, saturation, signs and masking.
   // ------------------------------------------------------------------
   logic [UQ:0]       uxq, uyq;
   logic [IQ:0]       ixq, iyq;
   logic [15:0]       jrx, jry;
   logic [31:0]       jbx, jby;
   rbmj_pkg::rsp_type rsp_in, rsp_ff;

   always_comb begin
      uxq = {1'b0, ux_quo[UQ]} + {{UQ{1'b0}}, (ux_rem[UQ] >= ux_den[UQ])};
      uyq = {1'b0, uy_quo[UQ]} + {{UQ{1'b0}}, (uy_rem[UQ] >= uy_den[UQ])};
      if (uxq > (UQ+1)'(16384)) uxq = (UQ+1)'(16384);
      if (uyq > (UQ+1)'(16384)) uyq = (UQ+1)'(16384);
      jrx = flag_pre.neg_x ? 16'(-uxq) : 16'(uxq);
      jry = flag_pre.neg_y ? 16'(-uyq) : 16'(uyq);

      ixq = inv_pre[2*IQ+1:IQ+1];
      iyq = inv_pre[IQ:0];
      if (flag_pre.pos_y) begin
         jbx = (ixq >= (IQ+1)'(34'h0_8000_0000)) ? 32'h8000_0000 : 32'(-ixq);
      end else begin
         jbx = (ixq > (IQ+1)'(34'h0_7FFF_FFFF)) ? 32'h7FFF_FFFF : ixq[31:0];
      end
      if (flag_pre.neg_x) begin
         jby = (iyq >= (IQ+1)'(34'h0_8000_0000)) ? 32'h8000_0000 : 32'(-iyq);
      end else begin
         jby = (iyq > (IQ+1)'(34'h0_7FFF_FFFF)) ? 32'h7FFF_FFFF : iyq[31:0];
      end

      rsp_in.range_out      = flag_pre.degen ? 33'd0 : rng_pre;
      rsp_in.bearing_out    = brg_pre;
      rsp_in.jac_range_lx   = flag_pre.degen ? 16'd0 : jrx;
      rsp_in.jac_bearing_lx = flag_pre.degen ? 32'd0 : jbx;
      rsp_in.jac_range_ly   = flag_pre.degen ? 16'd0 : jry;
      rsp_in.jac_bearing_ly = flag_pre.degen ? 32'd0 : jby;
      rsp_in.degenerate     = flag_pre.degen;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_data = rsp_ff;

   // ------------------------------------------------------------------
   // Assertions.
   // ------------------------------------------------------------------

   // A landmark on the vehicle yields zero range and zero Jacobian terms.
   a_degen_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.degenerate |->
         rsp_data.range_out == '0 && rsp_data.jac_range_lx == '0 &&
         rsp_data.jac_range_ly == '0 && rsp_data.jac_bearing_lx == '0 &&
         rsp_data.jac_bearing_ly == '0)
      else $error("degenerate result carries nonzero terms");

   // The wrapped bearing always lies within plus or minus pi.
   a_brg_wrap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.bearing_out <= rbmj_pkg::PI_Q13 &&
                    rsp_data.bearing_out >= -rbmj_pkg::PI_Q13)
      else $error("bearing outside plus or minus pi");

   // Unit terms never exceed one in magnitude.
   a_unit_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.jac_range_lx <= 16'sd16384 &&
                    rsp_data.jac_range_lx >= -16'sd16384 &&
                    rsp_data.jac_range_ly <= 16'sd16384 &&
                    rsp_data.jac_range_ly >= -16'sd16384)
      else $error("unit Jacobian term out of range");

   // A held result freezes the pipeline, so a valid result is still shown next cycle and req_stall follows rsp_stall.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && req_stall == rsp_stall)
      else $error("stalled result lost or input side not held");

endmodule
